>>> hw/rtl/mcd_pkg.sv
// ----------------------------------------------------------------------------
// mcd_pkg
// Shared widths, codes and reset values for the media clock discipline core.
// ----------------------------------------------------------------------------
package mcd_pkg;

	// field widths
	localparam int OP_W       = 2;
	localparam int CLOCK_W    = 62;
	localparam int PROC_W     = 40;
	localparam int BYTES_W    = 21;
	localparam int BYTES_MAG_W = BYTES_W - 1;
	localparam int NPB_W      = 32;
	localparam int GAIN_W     = 16;
	localparam int SNAP_W     = 40;

	// stream packing
	localparam int IN_DATA_W  = 192;
	localparam int OUT_DATA_W = 64;
	localparam int START_LSB  = 0;
	localparam int PROC_LSB   = START_LSB + CLOCK_W;
	localparam int BYTES_LSB  = PROC_LSB + PROC_W;
	localparam int WALL_LSB   = BYTES_LSB + BYTES_W;

	// config port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 40;

	// shared multiplier
	localparam int MUL_W          = 32;
	localparam int BYTE_FRAC_BITS = 16;
	localparam int Q_LIMIT_BITS   = 46;
	localparam logic [MUL_W-1:0] NS_PER_US = 32'd1000;

	// parameter defaults
	localparam int TIME_BITS_DEF      = 64;
	localparam int GAIN_FRAC_BITS_DEF = 16;

	// register reset values
	localparam logic [NPB_W-1:0]  NPB_RST   = 32'd341333;
	localparam logic [GAIN_W-1:0] LGAIN_RST = 16'd1311;
	localparam logic [GAIN_W-1:0] SGAIN_RST = 16'd3277;
	localparam logic [SNAP_W-1:0] SNAP_RST  = 40'd250000000;

	typedef logic [OP_W-1:0]      mcd_op_t;
	typedef logic [CFG_IDX_W-1:0] mcd_reg_idx_t;

	// item kinds
	localparam mcd_op_t OP_START = 2'd0;
	localparam mcd_op_t OP_QUERY = 2'd1;
	localparam mcd_op_t OP_STOP  = 2'd2;
	localparam mcd_op_t OP_HOLD  = 2'd3;

	// register indexes
	localparam mcd_reg_idx_t REG_NS_PER_BYTE = 2'd0;
	localparam mcd_reg_idx_t REG_LAT_GAIN    = 2'd1;
	localparam mcd_reg_idx_t REG_SLEW_GAIN   = 2'd2;
	localparam mcd_reg_idx_t REG_SNAP_LIMIT  = 2'd3;

endpackage

>>> hw/rtl/media_clock_discipline_core.sv
// ----------------------------------------------------------------------------
// media_clock_discipline_core
// Wall-time media clock, disciplined by audio device progress.
// ----------------------------------------------------------------------------
// Sequencing: start, stop and unused-code beats and stopped queries go from decode
//   to emit; a running query walks the datapath steps first. Emit waits for output room.
// Flow: one beat at a time, accepted only when idle; every step runs through one shared
//   32x32 multiplier and one shared add/subtract with saturation.
// Reset: async, active low; clears run/lock/seed state, the time registers and
//   the output valid, and loads the config register defaults.
module media_clock_discipline_core
	import mcd_pkg::*;
#(
	parameter int TIME_BITS      = TIME_BITS_DEF,
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// config write port
	input  logic                  cfg_we,
	input  mcd_reg_idx_t          cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input beats
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// start_time_ns[61:0], processed_us[101:62], in_flight_bytes[122:102],
	// wall_ns[184:123], zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// op[1:0]
	input  mcd_op_t               s_axis_tuser,
	// result beats
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// clock_ns[61:0], zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// playing[0]
	output logic                  m_axis_tuser
);

	// Signed times carry TIME_BITS bits and saturate at +-TMAX = 2^(TIME_BITS-2)-1,
	// so a magnitude fits MAG_W bits. The adder is wide enough for a 62-bit wall
	// difference and for sums of two saturated times.
	localparam int MAG_W = TIME_BITS - 2;
	localparam int ACC_W = MAG_W + GAIN_W;
	localparam int ADD_W = (TIME_BITS > CLOCK_W) ? TIME_BITS : CLOCK_W + 1;
	localparam logic [MAG_W-1:0] TMAX_M = {MAG_W{1'b1}};
	localparam logic signed [ADD_W-1:0] TMAX_S = $signed(ADD_W'(TMAX_M));

	// sequencer codes
	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_DECODE  = 5'd1;
	localparam logic [4:0] ST_LAT     = 5'd2;
	localparam logic [4:0] ST_LDIFF   = 5'd3;
	localparam logic [4:0] ST_LABS    = 5'd4;
	localparam logic [4:0] ST_MUL_LO  = 5'd5;
	localparam logic [4:0] ST_MUL_HI  = 5'd6;
	localparam logic [4:0] ST_GFIN    = 5'd7;
	localparam logic [4:0] ST_LAPPLY  = 5'd8;
	localparam logic [4:0] ST_PROC_LO = 5'd9;
	localparam logic [4:0] ST_PROC_HI = 5'd10;
	localparam logic [4:0] ST_RAWD    = 5'd11;
	localparam logic [4:0] ST_RAWS    = 5'd12;
	localparam logic [4:0] ST_ELAP    = 5'd13;
	localparam logic [4:0] ST_PRED    = 5'd14;
	localparam logic [4:0] ST_ERR     = 5'd15;
	localparam logic [4:0] ST_EABS    = 5'd16;
	localparam logic [4:0] ST_SNAP    = 5'd17;
	localparam logic [4:0] ST_SAPPLY  = 5'd18;
	localparam logic [4:0] ST_CAND    = 5'd19;
	localparam logic [4:0] ST_EMIT    = 5'd20;

	function automatic logic signed [ADD_W-1:0] sat_time(input logic signed [ADD_W-1:0] v);
		logic signed [ADD_W-1:0] r;
		r = v;
		if (v < 0)
			r = '0;
		else if (v > TMAX_S)
			r = TMAX_S;
		return r;
	endfunction

	function automatic logic signed [ADD_W-1:0] sat_signed(input logic signed [ADD_W-1:0] v);
		logic signed [ADD_W-1:0] r;
		r = v;
		if (v > TMAX_S)
			r = TMAX_S;
		else if (v < -TMAX_S)
			r = -TMAX_S;
		return r;
	endfunction

	// config registers
	logic [NPB_W-1:0]  npb_q;
	logic [GAIN_W-1:0] lat_gain_q;
	logic [GAIN_W-1:0] slew_gain_q;
	logic [SNAP_W-1:0] snap_q;

	// control and clock state
	logic [4:0] state_q;
	logic       running_q;
	logic       seeded_q;
	logic       locked_q;
	logic       m_valid_q;
	logic signed [TIME_BITS-1:0] start_q;
	logic signed [TIME_BITS-1:0] smoothed_q;
	logic signed [TIME_BITS-1:0] base_q;
	logic signed [TIME_BITS-1:0] last_q;
	logic [CLOCK_W-1:0]          origin_q;

	// captured beat
	mcd_op_t            op_q;
	logic [CLOCK_W-1:0] in_start_q;
	logic [PROC_W-1:0]  proc_q;
	logic [BYTES_MAG_W-1:0] bytes_q;
	logic [CLOCK_W-1:0] wall_q;

	// scratch
	logic signed [TIME_BITS-1:0] t_q;    // raw latency, then predicted clock
	logic signed [TIME_BITS-1:0] x_q;    // signed value fed to the gain product
	logic                        neg_q;
	logic [MAG_W-1:0]            mag_q;  // |x|, then gain product magnitude
	logic [ACC_W-1:0]            acc_q;
	logic signed [TIME_BITS-1:0] d_q;
	logic signed [TIME_BITS-1:0] raw_q;
	logic signed [TIME_BITS-1:0] el_q;
	logic                        pass_q; // 0 latency smoothing, 1 slew
	logic [CLOCK_W-1:0]          res_clk_q;
	logic                        res_play_q;
	logic [CLOCK_W-1:0]          out_clk_q;
	logic                        out_play_q;

	// shared units
	logic signed [ADD_W-1:0] add_a, add_b, add_sum, sat_t, sat_s, wrap_v;
	logic                    add_sub;
	logic [MUL_W-1:0]        mul_a, mul_b;
	logic [2*MUL_W-1:0]      mul_p;
	logic [ACC_W-1:0]        gshift;
	logic                    q_big;
	logic [MAG_W-1:0]        gain_res;
	logic [ADD_W-1:0]        start_sat;
	logic signed [TIME_BITS-1:0] rawlat_w;
	logic                    out_load;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'(out_clk_q);
	assign m_axis_tuser  = out_play_q;
	assign out_load      = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready);

	// Adder operand select: one add or subtract per sequencer step.
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		unique case (state_q)
			ST_LDIFF: begin
				add_a   = ADD_W'(t_q);
				add_b   = ADD_W'(smoothed_q);
				add_sub = 1'b1;
			end
			ST_LABS, ST_EABS: begin
				add_b   = ADD_W'(x_q);
				add_sub = neg_q;
			end
			ST_LAPPLY: begin
				add_a   = ADD_W'(smoothed_q);
				add_b   = $signed(ADD_W'(mag_q));
				add_sub = neg_q;
			end
			ST_RAWD: begin
				add_a   = $signed(ADD_W'(acc_q));
				add_b   = ADD_W'(smoothed_q);
				add_sub = 1'b1;
			end
			ST_RAWS: begin
				add_a = ADD_W'(start_q);
				add_b = ADD_W'(d_q);
			end
			ST_ELAP: begin
				add_a   = $signed(ADD_W'(wall_q));
				add_b   = $signed(ADD_W'(origin_q));
				add_sub = 1'b1;
			end
			ST_PRED, ST_CAND: begin
				add_a = ADD_W'(base_q);
				add_b = ADD_W'(el_q);
			end
			ST_ERR: begin
				add_a   = ADD_W'(raw_q);
				add_b   = ADD_W'(t_q);
				add_sub = 1'b1;
			end
			ST_SNAP: begin
				add_a   = ADD_W'(raw_q);
				add_b   = ADD_W'(el_q);
				add_sub = 1'b1;
			end
			ST_SAPPLY: begin
				add_a   = ADD_W'(base_q);
				add_b   = $signed(ADD_W'(mag_q));
				add_sub = neg_q;
			end
			default: begin
			end
		endcase
	end

	assign add_sum = $signed(add_a + (add_sub ? ~add_b : add_b) + ADD_W'(add_sub));
	assign sat_t   = sat_time(add_sum);
	assign sat_s   = sat_signed(add_sum);
	// elapsed wall time wraps modulo 2^62
	assign wrap_v  = sat_time($signed(ADD_W'(add_sum[CLOCK_W-1:0])));

	// Multiplier operand select; wide products take a low and a high pass.
	always_comb begin
		mul_a = '0;
		mul_b = 32'(pass_q ? slew_gain_q : lat_gain_q);
		unique case (state_q)
			ST_LAT: begin
				mul_a = 32'(bytes_q);
				mul_b = npb_q;
			end
			ST_MUL_LO:  mul_a = mag_q[MUL_W-1:0];
			ST_MUL_HI:  mul_a = 32'(mag_q >> MUL_W);
			ST_PROC_LO: begin
				mul_a = proc_q[MUL_W-1:0];
				mul_b = NS_PER_US;
			end
			ST_PROC_HI: begin
				mul_a = 32'(proc_q >> MUL_W);
				mul_b = NS_PER_US;
			end
			default: begin
			end
		endcase
	end

	assign mul_p    = mul_a * mul_b;
	assign rawlat_w = $signed(TIME_BITS'(mul_p >> BYTE_FRAC_BITS));

	// Gain product: magnitude truncated toward zero, saturated at TMAX.
	assign gshift   = acc_q >> GAIN_FRAC_BITS;
	assign q_big    = (mag_q >> (GAIN_FRAC_BITS + Q_LIMIT_BITS)) != '0;
	assign gain_res = (q_big || (gshift > ACC_W'(TMAX_M))) ? TMAX_M : MAG_W'(gshift);

	assign start_sat = (ADD_W'(in_start_q) > ADD_W'(TMAX_M)) ? ADD_W'(TMAX_M)
		: ADD_W'(in_start_q);

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			npb_q       <= NPB_RST;
			lat_gain_q  <= LGAIN_RST;
			slew_gain_q <= SGAIN_RST;
			snap_q      <= SNAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NS_PER_BYTE: npb_q       <= cfg_data[NPB_W-1:0];
				REG_LAT_GAIN:    lat_gain_q  <= cfg_data[GAIN_W-1:0];
				REG_SLEW_GAIN:   slew_gain_q <= cfg_data[GAIN_W-1:0];
				REG_SNAP_LIMIT:  snap_q      <= cfg_data[SNAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer and clock state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			running_q  <= 1'b0;
			seeded_q   <= 1'b0;
			locked_q   <= 1'b0;
			m_valid_q  <= 1'b0;
			start_q    <= '0;
			smoothed_q <= '0;
			base_q     <= '0;
			last_q     <= '0;
			origin_q   <= '0;
		end else begin
			if (out_load)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid)
						state_q <= ST_DECODE;
				end
				ST_DECODE: begin
					// only a running query enters the datapath
					state_q <= (op_q == OP_QUERY && running_q) ? ST_LAT : ST_EMIT;
					unique case (op_q)
						OP_START: begin
							running_q  <= 1'b1;
							seeded_q   <= 1'b0;
							locked_q   <= 1'b0;
							smoothed_q <= '0;
							start_q    <= TIME_BITS'(start_sat);
							base_q     <= TIME_BITS'(start_sat);
							last_q     <= TIME_BITS'(start_sat);
						end
						OP_STOP:  running_q <= 1'b0;
						OP_QUERY: begin
						end
						OP_HOLD: begin
						end
						default: begin
						end
					endcase
				end
				ST_LAT: begin
					// first sample seeds the average
					if (!seeded_q) begin
						smoothed_q <= rawlat_w;
						seeded_q   <= 1'b1;
						state_q    <= ST_PROC_LO;
					end else begin
						state_q <= ST_LDIFF;
					end
				end
				ST_LDIFF:   state_q <= ST_LABS;
				ST_LABS:    state_q <= ST_MUL_LO;
				ST_MUL_LO:  state_q <= ST_MUL_HI;
				ST_MUL_HI:  state_q <= ST_GFIN;
				ST_GFIN:    state_q <= pass_q ? ST_SAPPLY : ST_LAPPLY;
				ST_LAPPLY: begin
					smoothed_q <= TIME_BITS'(add_sum);
					state_q    <= ST_PROC_LO;
				end
				ST_PROC_LO: state_q <= ST_PROC_HI;
				ST_PROC_HI: state_q <= ST_RAWD;
				ST_RAWD:    state_q <= ST_RAWS;
				ST_RAWS: begin
					// first query after start locks the wall origin
					if (!locked_q) begin
						locked_q <= 1'b1;
						origin_q <= wall_q;
						base_q   <= TIME_BITS'(sat_t);
						last_q   <= TIME_BITS'(sat_t);
						state_q  <= ST_EMIT;
					end else begin
						state_q <= ST_ELAP;
					end
				end
				ST_ELAP:    state_q <= ST_PRED;
				ST_PRED:    state_q <= ST_ERR;
				ST_ERR:     state_q <= ST_EABS;
				ST_EABS: begin
					if (add_sum > $signed(ADD_W'(snap_q)))
						state_q <= ST_SNAP;
					else
						state_q <= ST_MUL_LO;
				end
				ST_SNAP, ST_SAPPLY: begin
					base_q  <= TIME_BITS'(sat_s);
					state_q <= ST_CAND;
				end
				ST_CAND: begin
					// clock never runs backwards
					if (sat_t > ADD_W'(last_q))
						last_q <= TIME_BITS'(sat_t);
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath scratch and result registers
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_clk_q  <= res_clk_q;
			out_play_q <= res_play_q;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					op_q       <= s_axis_tuser;
					in_start_q <= s_axis_tdata[START_LSB +: CLOCK_W];
					proc_q     <= s_axis_tdata[PROC_LSB +: PROC_W];
					wall_q     <= s_axis_tdata[WALL_LSB +: CLOCK_W];
					// negative in-flight count reads as zero
					bytes_q    <= s_axis_tdata[BYTES_LSB + BYTES_W - 1] ? '0
						: s_axis_tdata[BYTES_LSB +: BYTES_MAG_W];
				end
				pass_q <= 1'b0;
			end
			ST_DECODE: begin
				unique case (op_q)
					OP_START: begin
						res_clk_q  <= CLOCK_W'(start_sat);
						res_play_q <= 1'b1;
					end
					OP_HOLD: begin
						res_clk_q  <= running_q ? CLOCK_W'($unsigned(last_q)) : '0;
						res_play_q <= running_q;
					end
					default: begin
						res_clk_q  <= '0;
						res_play_q <= 1'b0;
					end
				endcase
			end
			ST_LAT: t_q <= rawlat_w;
			ST_LDIFF: begin
				x_q   <= TIME_BITS'(add_sum);
				neg_q <= add_sum[ADD_W-1];
			end
			ST_LABS: mag_q <= MAG_W'(add_sum);
			ST_EABS: begin
				mag_q  <= MAG_W'(add_sum);
				pass_q <= 1'b1;
			end
			ST_MUL_LO, ST_PROC_LO: acc_q <= ACC_W'(mul_p);
			ST_MUL_HI, ST_PROC_HI: acc_q <= acc_q + (ACC_W'(mul_p) << MUL_W);
			ST_GFIN: mag_q <= gain_res;
			ST_RAWD: d_q <= TIME_BITS'(sat_t);
			ST_RAWS: begin
				raw_q      <= TIME_BITS'(sat_t);
				res_clk_q  <= CLOCK_W'($unsigned(sat_t));
				res_play_q <= 1'b1;
			end
			ST_ELAP: el_q <= TIME_BITS'(wrap_v);
			ST_PRED: t_q <= TIME_BITS'(sat_s);
			ST_ERR: begin
				x_q   <= TIME_BITS'(sat_s);
				neg_q <= sat_s[ADD_W-1];
			end
			ST_CAND: begin
				res_clk_q  <= (sat_t > ADD_W'(last_q)) ? CLOCK_W'($unsigned(sat_t))
					: CLOCK_W'($unsigned(last_q));
				res_play_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTH
	// lock is only reached after the latency average was seeded
	a_lock_needs_seed: assert property (@(posedge clk) disable iff (!arst_n)
		locked_q |-> seeded_q)
		else $error("clock locked without a seeded latency");

	// the candidate step never moves the returned clock backwards
	a_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CAND) |=> (last_q >= $past(last_q)))
		else $error("last clock decreased");

	// one beat at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while busy");

	// a result only leaves through the emit step
	a_emit_path: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> ($past(state_q) == ST_EMIT))
		else $error("result valid raised outside emit");
`endif

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level check of the media clock discipline core. A behavioral
// predictor tracks the run/seed/lock state and the four registers, computes
// the clock and playing flag for every accepted input beat, and a checker
// compares each result beat against the oldest prediction. Directed edge
// cases come first, then randomized playback sessions under several
// register settings, with bursty input traffic and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_top
	import mcd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          GAIN_FB     = GAIN_FRAC_BITS_DEF;
	localparam longint      TMAX        = (longint'(1) <<< 62) - 1;
	localparam int          CYCLE_LIMIT = 500000;
	localparam logic [61:0] WALL_TOP    = 62'h3FFF_FFFF_FFFF_FFFF;

	// one input beat, unpacked
	typedef struct {
		mcd_op_t     op;
		logic [61:0] start_ns;
		logic [39:0] proc_us;
		logic [20:0] bytes;
		logic [61:0] wall_ns;
	} media_beat_t;

	// one predicted result beat
	typedef struct {
		logic [61:0] clock_ns;
		logic        playing;
	} media_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	mcd_reg_idx_t          cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	mcd_op_t               s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;

	media_clock_discipline_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #4 clk = ~clk;

	// predictor copy of the register file
	logic [NPB_W-1:0]  npb_q16;
	logic [GAIN_W-1:0] lat_gain;
	logic [GAIN_W-1:0] slew_gain;
	logic [SNAP_W-1:0] snap_ns;

	// predictor copy of the playback state
	logic        is_running;
	longint      origin_start;
	logic        lat_seeded;
	longint      lat_avg;
	logic        locked;
	longint      base_ns;
	logic [63:0] wall_zero;
	longint      held_clock;

	media_result_t clock_queue[$];

	int  cycle_count   = 0;
	int  mismatches    = 0;
	int  beats_sent    = 0;
	int  results_seen  = 0;
	int  sessions      = 0;
	int  snap_events   = 0;
	int  slew_events   = 0;
	int  holdoffs      = 0;
	int  burst_left    = 0;
	bit  steady        = 1'b0;   // no idling on either side while set
	int  ready_run     = 0;
	logic ready_now    = 1'b1;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// ------------------------------------------------------------------
	// Saturating arithmetic, 64-bit time base (TMAX = 2^62-1)
	// ------------------------------------------------------------------
	function automatic longint clamp_time(longint x);
		if (x < 0) return 0;
		if (x > TMAX) return TMAX;
		return x;
	endfunction

	function automatic longint clamp_signed(longint x);
		if (x > TMAX) return TMAX;
		if (x < -TMAX) return -TMAX;
		return x;
	endfunction

	// gain product rounded toward zero: sign(x) * ((|x| * g) >> frac)
	function automatic longint scale_by_gain(longint x, logic [GAIN_W-1:0] g);
		logic        neg;
		logic [63:0] mag, q, r, res;
		neg = (x < 0);
		mag = neg ? 64'(-x) : 64'(x);
		q   = mag >> GAIN_FB;
		r   = mag & ((64'd1 << GAIN_FB) - 64'd1);
		if (q >= (64'd1 << Q_LIMIT_BITS)) begin
			res = 64'(TMAX);
		end else begin
			res = q * 64'(g) + ((r * 64'(g)) >> GAIN_FB);
			if (res > 64'(TMAX)) res = 64'(TMAX);
		end
		return neg ? -longint'(res) : longint'(res);
	endfunction

	// ------------------------------------------------------------------
	// Predictor: advance the state by one accepted beat, queue the result
	// ------------------------------------------------------------------
	task automatic predict_clock(media_beat_t b);
		logic [63:0]   nbytes;
		logic [63:0]   amag;
		longint        raw_lat, proc_ns, diff, raw, elapsed, pred, err, cand;
		media_result_t res;
		res.clock_ns = '0;
		res.playing  = 1'b0;
		case (b.op)
			OP_START: begin
				// restart clears seed and lock, whatever the previous state
				origin_start = clamp_time(longint'({2'b00, b.start_ns}));
				lat_seeded   = 1'b0;
				lat_avg      = 0;
				locked       = 1'b0;
				base_ns      = origin_start;
				held_clock   = origin_start;
				is_running   = 1'b1;
				res.clock_ns = origin_start[61:0];
				res.playing  = 1'b1;
			end
			OP_STOP: begin
				is_running = 1'b0;
			end
			OP_QUERY: begin
				if (is_running) begin
					// negative in-flight count reads as empty buffer
					nbytes  = b.bytes[BYTES_W-1] ? 64'd0 : 64'(b.bytes[BYTES_MAG_W-1:0]);
					raw_lat = longint'((nbytes * 64'(npb_q16)) >> BYTE_FRAC_BITS);
					if (!lat_seeded) begin
						lat_avg    = raw_lat;
						lat_seeded = 1'b1;
					end else begin
						lat_avg = lat_avg + scale_by_gain(raw_lat - lat_avg, lat_gain);
					end
					proc_ns = longint'({24'd0, b.proc_us}) * 1000;
					diff    = proc_ns - lat_avg;
					if (diff < 0) diff = 0;
					raw = clamp_time(origin_start + clamp_time(diff));
					if (!locked) begin
						// first query after start pins the wall origin
						locked     = 1'b1;
						wall_zero  = {2'b00, b.wall_ns};
						base_ns    = raw;
						held_clock = raw;
					end else begin
						// elapsed wall time wraps modulo 2^62
						elapsed = clamp_time(longint'(({2'b00, b.wall_ns} - wall_zero)
							& {2'b00, WALL_TOP}));
						pred = clamp_signed(base_ns + elapsed);
						err  = clamp_signed(raw - pred);
						amag = (err < 0) ? 64'(-err) : 64'(err);
						if (amag > 64'(snap_ns)) begin
							base_ns = clamp_signed(raw - elapsed);
							snap_events++;
						end else begin
							base_ns = clamp_signed(base_ns + scale_by_gain(err, slew_gain));
							slew_events++;
						end
						// monotone output: never step backwards
						cand = clamp_time(base_ns + elapsed);
						if (cand > held_clock) held_clock = cand;
					end
					res.clock_ns = held_clock[61:0];
					res.playing  = 1'b1;
				end
			end
			default: begin
				// unused code only reports, changes nothing
				if (is_running) begin
					res.clock_ns = held_clock[61:0];
					res.playing  = 1'b1;
				end
			end
		endcase
		clock_queue.push_back(res);
	endtask

	// ------------------------------------------------------------------
	// Result checker: every accepted result beat against the oldest entry
	// ------------------------------------------------------------------
	task automatic flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] %s mismatch: expected %0d, got %0d", $time, what, want, got);
	endtask

	always @(posedge clk) begin
		media_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (clock_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] result beat with nothing outstanding: clock %0d playing %0b",
						$time, m_axis_tdata[CLOCK_W-1:0], m_axis_tuser);
			end else begin
				want = clock_queue.pop_front();
				if (m_axis_tdata[CLOCK_W-1:0] !== want.clock_ns)
					flag_mismatch("clock_ns", 64'(want.clock_ns), 64'(m_axis_tdata[CLOCK_W-1:0]));
				if (m_axis_tuser !== want.playing)
					flag_mismatch("playing", 64'(want.playing), 64'(m_axis_tuser));
			end
		end
	end

	// Receiver: alternating ready/stall runs of random length
	always @(negedge clk) begin
		if (steady) begin
			m_axis_tready = 1'b1;
		end else begin
			if (ready_run == 0) begin
				ready_now = !ready_now;
				ready_run = ready_now ? $urandom_range(1, 14) : $urandom_range(1, 6);
			end else begin
				ready_run--;
			end
			m_axis_tready = ready_now;
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// drop valid and wait until every outstanding result has drained
	task automatic settle_results();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (clock_queue.size() != 0) @(posedge clk);
	endtask

	// bursts of beats separated by random gaps; rarely a full hold-off
	task automatic pace_sender();
		if (!steady) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				@(negedge clk);
				s_axis_tvalid = 1'b0;
				if ($urandom_range(0, 40) == 0) begin
					holdoffs++;
					while (clock_queue.size() != 0) @(posedge clk);
				end
				repeat ($urandom_range(0, 7)) @(negedge clk);
				burst_left = $urandom_range(0, 10);
			end
		end
	endtask

	task automatic send_beat(media_beat_t b);
		logic [IN_DATA_W-1:0] packed_beat;
		packed_beat = '0;
		packed_beat[START_LSB +: CLOCK_W] = b.start_ns;
		packed_beat[PROC_LSB  +: PROC_W]  = b.proc_us;
		packed_beat[BYTES_LSB +: BYTES_W] = b.bytes;
		packed_beat[WALL_LSB  +: CLOCK_W] = b.wall_ns;
		@(negedge clk);
		s_axis_tuser  = b.op;
		s_axis_tdata  = packed_beat;
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_clock(b);
		beats_sent++;
		pace_sender();
	endtask

	// registers change only with the core idle
	task automatic set_registers(logic [NPB_W-1:0] npb, logic [GAIN_W-1:0] lg,
			logic [GAIN_W-1:0] sg, logic [SNAP_W-1:0] snap);
		logic [CFG_DATA_W-1:0] vals[4];
		vals[REG_NS_PER_BYTE] = CFG_DATA_W'(npb);
		vals[REG_LAT_GAIN]    = CFG_DATA_W'(lg);
		vals[REG_SLEW_GAIN]   = CFG_DATA_W'(sg);
		vals[REG_SNAP_LIMIT]  = CFG_DATA_W'(snap);
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_we    = 1'b1;
			cfg_index = mcd_reg_idx_t'(i);
			cfg_data  = vals[i];
		end
		@(negedge clk);
		cfg_we = 1'b0;
		npb_q16   = npb;
		lat_gain  = lg;
		slew_gain = sg;
		snap_ns   = snap;
	endtask

	function automatic logic [61:0] rand62();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [39:0] rand40();
		return {8'($urandom), $urandom};
	endfunction

	function automatic media_beat_t noise_beat(mcd_op_t op);
		media_beat_t b;
		b.op       = op;
		b.start_ns = rand62();
		b.proc_us  = rand40();
		b.bytes    = 21'($urandom);
		b.wall_ns  = rand62();
		return b;
	endfunction

	function automatic media_beat_t query_beat(logic [39:0] pu, logic [20:0] fb,
			logic [61:0] wn);
		media_beat_t b;
		b         = noise_beat(OP_QUERY);
		b.proc_us = pu;
		b.bytes   = fb;
		b.wall_ns = wn;
		return b;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// stopped-state behavior, first lock, clamps, wrap, restart; reset registers
	task automatic test_reset_defaults();
		media_beat_t b;
		send_beat(noise_beat(OP_QUERY));                // query while stopped
		send_beat(noise_beat(OP_HOLD));                 // unused code while stopped
		send_beat(noise_beat(OP_STOP));                 // stop while stopped
		b = noise_beat(OP_START);
		b.start_ns = WALL_TOP;                          // largest start position
		send_beat(b);
		send_beat(noise_beat(OP_HOLD));                 // unused code while running
		send_beat(query_beat(40'd1000, 21'd4800, 62'd5000));   // seeds, locks, saturates
		b = noise_beat(OP_START);
		b.start_ns = '0;                                // restart while running
		send_beat(b);
		// processed behind latency: difference clamps to zero, origin at wall top
		send_beat(query_beat(40'd0, 21'h0F_FFFF, WALL_TOP));
		// wall wraps past 2^62
		send_beat(query_beat(40'd16000, 21'd0, 62'd16_000_000));
		send_beat(query_beat(40'd32000, 21'h1F_FFFF, 62'd32_000_000)); // -1 bytes
		send_beat(query_beat(40'd48000, 21'h10_0000, 62'd48_000_000)); // most negative
		send_beat(query_beat(40'hFF_FFFF_FFFF, 21'd100, 62'd64_000_000)); // big jump: snap
		send_beat(query_beat(40'hFF_FFFF_FFFF, 21'd100, 62'd64_000_016)); // slew
		send_beat(noise_beat(OP_STOP));
		send_beat(noise_beat(OP_QUERY));                // query after stop
		send_beat(noise_beat(OP_HOLD));
		settle_results();
	endtask

	// short sessions with all registers at their top, then at the bottom
	task automatic test_register_extremes();
		logic [61:0] wall;
		logic [39:0] proc;
		for (int pass = 0; pass < 2; pass++) begin
			if (pass == 0)
				set_registers('1, '1, '1, '1);
			else
				set_registers('0, '0, '0, '0);   // zero ns per byte: in-flight bytes add nothing
			send_beat(noise_beat(OP_START));
			wall = rand62();
			proc = 40'($urandom_range(0, 1000000));
			for (int i = 0; i < 3; i++) begin
				send_beat(query_beat(proc, 21'($urandom_range(0, 1048575)), wall));
				proc = proc + 40'd16667 + 40'(i * 300000);
				wall = wall + 62'd16_666_667;
			end
			send_beat(noise_beat(OP_STOP));
			settle_results();
		end
	endtask

	// one playback session: start, paced queries with jitter, jumps and noise
	task automatic run_session(int n);
		media_beat_t b;
		logic [61:0] wall;
		logic [39:0] proc;
		logic [20:0] fb;
		int          r, frame_us, jit;
		sessions++;
		b = noise_beat(OP_START);
		if ($urandom_range(0, 7) != 0) b.start_ns = 62'($urandom) * 62'd1000;
		send_beat(b);
		wall = ($urandom_range(0, 5) == 0) ? WALL_TOP - 62'($urandom_range(0, 200000000))
			: rand62();
		proc = 40'($urandom_range(0, 200000));
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				send_beat(noise_beat(OP_HOLD));
			end else if (r < 10) begin
				send_beat(noise_beat(mcd_op_t'($urandom_range(0, 3))));
			end else begin
				frame_us = $urandom_range(1000, 40000);
				jit      = int'($urandom_range(0, 6000000)) - 3000000;
				if (r < 14)
					proc = proc + 40'($urandom_range(200000, 2000000));  // skip ahead
				else if (r >= 17)
					proc = proc + 40'(frame_us);                         // else underrun
				wall = wall + 62'(longint'(frame_us) * 1000 + longint'(jit));
				if (r < 22)
					fb = (r < 20) ? {1'b1, 20'($urandom)} : 21'($urandom_range(0, 1048575));
				else
					fb = 21'($urandom_range(0, 40000));
				send_beat(query_beat(proc, fb, wall));
			end
		end
		if ($urandom_range(0, 3) != 0) send_beat(noise_beat(OP_STOP));
	endtask

	// random register settings per phase, sessions until the phase quota
	task automatic test_streamed_sessions();
		logic [NPB_W-1:0]  npb;
		logic [GAIN_W-1:0] lg, sg;
		logic [SNAP_W-1:0] snap;
		int                target;
		for (int phase = 0; phase < 6; phase++) begin
			settle_results();
			case ($urandom_range(0, 3))
				0:       npb = NPB_RST;
				1:       npb = $urandom;
				2:       npb = 32'hFFFF_FFFF;
				default: npb = $urandom_range(1, 2000000);
			endcase
			lg = ($urandom_range(0, 4) == 0) ? GAIN_W'($urandom_range(0, 1) * 65535)
				: GAIN_W'($urandom);
			sg = ($urandom_range(0, 4) == 0) ? GAIN_W'($urandom_range(0, 1) * 65535)
				: GAIN_W'($urandom);
			case ($urandom_range(0, 3))
				0:       snap = SNAP_RST;
				1:       snap = rand40();
				2:       snap = SNAP_W'($urandom_range(0, 5000000));
				default: snap = '1;
			endcase
			set_registers(npb, lg, sg, snap);
			steady = (phase == 2);
			target = beats_sent + 90;
			while (beats_sent < target) run_session($urandom_range(4, 40));
		end
		steady = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Run
	// ------------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_NS_PER_BYTE;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = OP_STOP;
		m_axis_tready = 1'b0;
		npb_q16       = NPB_RST;
		lat_gain      = LGAIN_RST;
		slew_gain     = SGAIN_RST;
		snap_ns       = SNAP_RST;
		is_running    = 1'b0;
		origin_start  = 0;
		lat_seeded    = 1'b0;
		lat_avg       = 0;
		locked        = 1'b0;
		base_ns       = 0;
		wall_zero     = '0;
		held_clock    = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_register_extremes();
		test_streamed_sessions();

		settle_results();
		repeat (40) @(posedge clk);
		if (clock_queue.size() != 0) begin
			mismatches++;
			$display("%0d predicted results never arrived", clock_queue.size());
		end
		$display("Covered %0d beats in %0d random sessions, %0d result beats checked.",
			beats_sent, sessions, results_seen);
		$display("Base updates: %0d snaps, %0d slews; %0d sender hold-offs; %0d mismatches.",
			snap_events, slew_events, holdoffs, mismatches);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// watchdog
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results outstanding",
			cycle_count, clock_queue.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/mcd_pkg.sv
hw/rtl/media_clock_discipline_core.sv
tb/sv/tb_top.sv
